### src/sepc_pkg.sv
// Package for the stepper encoder position controller.
// Holds payload structs, status structs, register indexes and fixed constants.
// No dependencies; every other file of the block imports it.
package sepc_pkg;

  localparam int unsigned CountW   = 11;
  localparam int unsigned CentW    = 16;
  localparam int unsigned CentRemW = 7;
  localparam int unsigned AngleW   = 9;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned LockW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Full scale of the encoder count; the count wraps between 0 and this value.
  localparam logic [CountW-1:0] TopCount = 11'd1232;

  // Position in hundredths of a degree is round(count * 36000 / 1232), which
  // equals floor((count * 2250 + 38) / 77). It is tracked as a quotient and a
  // remainder; one count step adds 2250 = 29 * 77 + 17 to the numerator.
  localparam logic [CentW-1:0]    CentQStep = 16'd29;
  localparam logic [CentRemW-1:0] CentRStep = 7'd17;
  localparam logic [CentRemW-1:0] CentDiv   = 7'd77;
  localparam logic [CentRemW-1:0] CentRWrap = 7'd60;
  localparam logic [CentRemW-1:0] CentROff  = 7'd38;
  localparam logic [CentW-1:0]    CentTop   = 16'd36000;

  // Move target: floor(angle * 1232 / 360) = floor(angle * 154 / 45), done as
  // angle * 154 * ceil(2^21 / 45) >> 21, exact for angles up to 360.
  localparam logic [AngleW-1:0] AngleMax    = 9'd360;
  localparam logic [31:0]       TargetRecip = 32'd7177016;
  localparam int unsigned       TargetShift = 21;
  localparam logic [16:0]       AngleScale  = 17'd154;
  localparam logic [16:0]       CountScale  = 17'd45;

  // Reset values of the configuration registers.
  localparam logic [HalfW-1:0] HalfPeriodRst = 16'd1;
  localparam logic [LockW-1:0] LockoutRst    = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHalfPeriod = 2'd0,
    CfgRunEnable  = 2'd1,
    CfgRunDir     = 2'd2,
    CfgLockout    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KindTick = 1'b0,
    KindMove = 1'b1
  } kind_e;

  typedef struct packed {
    logic              kind;
    logic              enc_a;
    logic              enc_b;
    logic [AngleW-1:0] target_angle;
  } in_t;

  typedef struct packed {
    logic              step_out;
    logic              dir_out;
    logic              drive_enable;
    logic [CountW-1:0] position_count;
    logic [CentW-1:0]  position_centideg;
    logic              moving;
  } out_t;

  // Next encoder position, as seen after the current request.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CentW-1:0]  centideg;
  } enc_pos_t;

  // Positioner status after the current request.
  typedef struct packed {
    logic step_level;
    logic move_active;
    logic move_dir;
  } pos_status_t;

endpackage

### src/sepc_encoder.sv
// Quadrature decoder with edge lockout and a wrapping position count.
// Also tracks the position in hundredths of a degree incrementally.
// Depends on sepc_pkg.
module sepc_encoder import sepc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic             enc_a_i,
  input  logic             enc_b_i,
  input  logic [LockW-1:0] lockout_i,
  output enc_pos_t         pos_o
);

  logic              last_a_q, last_a_d;
  logic              last_b_q, last_b_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LockW-1:0]  since_q, since_d;
  logic [CentW-1:0]  cent_q, cent_d;
  logic [CentRemW-1:0] rem_q, rem_d;

  logic              edge_a, edge_b, take, up;
  logic [LockW-1:0]  since_inc;
  logic [CentRemW-1:0] rem_sum;

  always_comb begin
    last_a_d  = last_a_q;
    last_b_d  = last_b_q;
    count_d   = count_q;
    since_d   = since_q;
    cent_d    = cent_q;
    rem_d     = rem_q;
    edge_a    = enc_a_i != last_a_q;
    edge_b    = enc_b_i != last_b_q;
    since_inc = (since_q == '1) ? since_q : since_q + LockW'(1);
    take      = (edge_a || edge_b) && (since_inc > lockout_i);
    up        = edge_a ? (enc_a_i == enc_b_i) : (enc_a_i != enc_b_i);
    rem_sum   = rem_q + CentRStep;
    if (tick_i) begin
      last_a_d = enc_a_i;
      last_b_d = enc_b_i;
      since_d  = take ? '0 : since_inc;
      if (take) begin
        if (up) begin
          if (count_q >= TopCount) begin
            count_d = '0;
            cent_d  = '0;
            rem_d   = CentROff;
          end else begin
            count_d = count_q + CountW'(1);
            if (rem_sum >= CentDiv) begin
              rem_d  = rem_sum - CentDiv;
              cent_d = cent_q + CentQStep + CentW'(1);
            end else begin
              rem_d  = rem_sum;
              cent_d = cent_q + CentQStep;
            end
          end
        end else begin
          if (count_q == '0) begin
            count_d = TopCount;
            cent_d  = CentTop;
            rem_d   = CentROff;
          end else begin
            count_d = count_q - CountW'(1);
            if (rem_q >= CentRStep) begin
              rem_d  = rem_q - CentRStep;
              cent_d = cent_q - CentQStep;
            end else begin
              rem_d  = rem_q + CentRWrap;
              cent_d = cent_q - CentQStep - CentW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
      last_b_q <= 1'b0;
      count_q  <= '0;
      since_q  <= '1;
      cent_q   <= '0;
      rem_q    <= CentROff;
    end else begin
      last_a_q <= last_a_d;
      last_b_q <= last_b_d;
      count_q  <= count_d;
      since_q  <= since_d;
      cent_q   <= cent_d;
      rem_q    <= rem_d;
    end
  end

  assign pos_o.count    = count_d;
  assign pos_o.centideg = cent_d;

endmodule

### src/sepc_positioner.sv
// Step pulse generator and move sequencer.
// Takes the next encoder count from sepc_encoder; depends on sepc_pkg.
module sepc_positioner import sepc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              move_i,
  input  logic [AngleW-1:0] angle_i,
  input  logic [CountW-1:0] count_i,
  input  logic [HalfW-1:0]  half_period_i,
  input  logic              run_enable_i,
  output pos_status_t       status_o
);

  logic [HalfW-1:0]  timer_q, timer_d;
  logic              phase_q, phase_d;
  logic              active_q, active_d;
  logic [CountW-1:0] target_q, target_d;
  logic              dir_q, dir_d;

  logic [HalfW-1:0]  half_eff, timer_inc;
  logic              boundary, active_tick, stepping;
  logic [AngleW-1:0] angle_sat;
  logic [31:0]       target_prod;
  logic [16:0]       angle_scaled, count_scaled;
  logic              level;

  always_comb begin
    half_eff     = (half_period_i == '0) ? HalfW'(1) : half_period_i;
    boundary     = (timer_q == '0) && !phase_q;
    active_tick  = active_q && !(boundary && (count_i == target_q));
    stepping     = active_tick || run_enable_i || !boundary;
    timer_inc    = timer_q + HalfW'(1);
    angle_sat    = (angle_i > AngleMax) ? AngleMax : angle_i;
    target_prod  = 32'(angle_sat) * TargetRecip;
    angle_scaled = 17'(angle_sat) * AngleScale;
    count_scaled = 17'(count_i) * CountScale;

    timer_d  = timer_q;
    phase_d  = phase_q;
    active_d = active_q;
    target_d = target_q;
    dir_d    = dir_q;
    level    = !phase_q && (timer_q != '0);

    if (move_i) begin
      target_d = target_prod[TargetShift +: CountW];
      dir_d    = !(angle_scaled < count_scaled);
      active_d = 1'b1;
    end else if (tick_i) begin
      active_d = active_tick;
      if (!stepping) begin
        timer_d = '0;
        phase_d = 1'b0;
        level   = 1'b0;
      end else begin
        level = !phase_q;
        if (timer_inc >= half_eff) begin
          timer_d = '0;
          phase_d = !phase_q;
        end else begin
          timer_d = timer_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q  <= '0;
      phase_q  <= 1'b0;
      active_q <= 1'b0;
      target_q <= '0;
      dir_q    <= 1'b1;
    end else begin
      timer_q  <= timer_d;
      phase_q  <= phase_d;
      active_q <= active_d;
      target_q <= target_d;
      dir_q    <= dir_d;
    end
  end

  assign status_o.step_level  = level;
  assign status_o.move_active = active_d;
  assign status_o.move_dir    = dir_d;

endmodule

### src/sepc_out_buf.sv
// Result register with a skid stage, so a request is taken while a result waits.
// Depends on sepc_pkg for the result struct.
module sepc_out_buf import sepc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic stall_i,
  output out_t data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  out_t out_q, out_d;
  out_t skid_q, skid_d;
  logic pop;

  always_comb begin
    pop          = out_valid_q && !stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

### src/stepper_encoder_position_controller.sv
// Stepper encoder position controller: quadrature counter plus step positioner.
// Each result is registered in the output register or the skid stage. Throughput is
// one request per cycle while the skid stage is free; the output register and skid
// stage keep it while one result waits. Asynchronous active-low reset clears all
// state but result data, restores configuration defaults and needs no clearing pass.
module stepper_encoder_position_controller import sepc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel: one tick sample or one move command per request.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  // Result channel: one status word per request.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers. Writes must happen only while the block is idle,
  // which the block itself does not enforce; the port is always ready.
  logic [HalfW-1:0] half_period_q;
  logic             run_enable_q;
  logic             run_dir_q;
  logic [LockW-1:0] lockout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
      run_enable_q  <= 1'b0;
      run_dir_q     <= 1'b1;
      lockout_q     <= LockoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgHalfPeriod: half_period_q <= cfg_data_i[HalfW-1:0];
        CfgRunEnable:  run_enable_q  <= cfg_data_i[0];
        CfgRunDir:     run_dir_q     <= cfg_data_i[0];
        CfgLockout:    lockout_q     <= cfg_data_i[LockW-1:0];
        default: ;
      endcase
    end
  end

  // A request is taken whenever the skid stage is free. Tick requests advance the
  // encoder and pulse generator; move requests only load a target and start a move.
  logic        accept, tick, move;
  logic        buf_full;
  enc_pos_t    pos;
  pos_status_t status;
  out_t        result;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;
  assign tick       = accept && (kind_e'(in_data_i.kind) == KindTick);
  assign move       = accept && (kind_e'(in_data_i.kind) == KindMove);

  sepc_encoder u_encoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .enc_a_i   (in_data_i.enc_a),
    .enc_b_i   (in_data_i.enc_b),
    .lockout_i (lockout_q),
    .pos_o     (pos)
  );

  // The positioner sees the count after this tick's encoder update, so a move can
  // end on the same tick that the encoder reaches the target, if at a pulse boundary.
  sepc_positioner u_positioner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (tick),
    .move_i        (move),
    .angle_i       (in_data_i.target_angle),
    .count_i       (pos.count),
    .half_period_i (half_period_q),
    .run_enable_i  (run_enable_q),
    .status_o      (status)
  );

  // Direction follows the move while one is active, else the free-run setting.
  always_comb begin
    result.step_out          = status.step_level;
    result.dir_out           = status.move_active ? status.move_dir : run_dir_q;
    result.drive_enable      = status.move_active || run_enable_q;
    result.position_count    = pos.count;
    result.position_centideg = pos.centideg;
    result.moving            = status.move_active;
  end

  sepc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule

### src/sepc_checker.sv
// Port-level assertions for the stepper encoder position controller.
// Depends on sepc_pkg; bound to the top level at the end of this file.
module sepc_checker import sepc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // A result that is held back stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Requests are held back only while a result is waiting.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stall without a pending result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.position_count <= TopCount)
    else $error("position count beyond full scale");

  // The incremental angle tracker must agree with the count at both ends.
  a_cent_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.position_count != '0 || out_data_o.position_centideg == '0) &&
      (out_data_o.position_count != TopCount ||
       out_data_o.position_centideg == CentTop))
    else $error("angle out of step with count");

  a_move_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.moving |-> out_data_o.drive_enable)
    else $error("driver disabled during a move");

endmodule

bind stepper_encoder_position_controller sepc_checker u_sepc_checker (.*);

### test/tb.sv
// Self-checking testbench for stepper_encoder_position_controller.
// Depends on sepc_pkg and the controller RTL; it predicts every status result
// from its own model of the encoder counter and step positioner.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sepc_pkg::*;

  // Generous bound: roughly 450 requests with the worst-case sender and receiver
  // gaps, plus the long receiver hold-off and the configuration pauses.
  localparam int CycleLimit = 200000;
  localparam int DegPerTurn = 360;
  localparam int EdgeSatur  = 255;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  stepper_encoder_position_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Status words the block still owes, oldest first.
  out_t pending_status[$];
  int   mismatch_count;
  int   items_sent;
  int   cycle_count;
  int   sender_gap_max;
  int   receiver_gap_max;
  // Set by a test, counted down by the result monitor once per cycle.
  int   hold_off_left;

  // Predictor copy of the configuration registers.
  logic [HalfW-1:0] m_half_period;
  logic             m_run_en;
  logic             m_run_dir;
  logic [LockW-1:0] m_lockout;

  // Predictor copy of the encoder counter and positioner state.
  logic m_last_a;
  logic m_last_b;
  int   m_count;
  int   m_since_edge;
  int   m_half_timer;
  logic m_phase;        // 0 while the step output is in its high half
  logic m_move_active;
  int   m_move_target;
  logic m_move_dir;

  function automatic void reset_model();
    m_half_period = HalfPeriodRst;
    m_run_en      = 1'b0;
    m_run_dir     = 1'b1;
    m_lockout     = LockoutRst;
    m_last_a      = 1'b0;
    m_last_b      = 1'b0;
    m_count       = 0;
    m_since_edge  = EdgeSatur;
    m_half_timer  = 0;
    m_phase       = 1'b0;
    m_move_active = 1'b0;
    m_move_target = 0;
    m_move_dir    = 1'b1;
  endfunction

  // One accepted encoder edge; the count wraps both ways at the full scale.
  function automatic void bump_count(bit up);
    if (up) begin
      m_count = (m_count >= int'(TopCount)) ? 0 : m_count + 1;
    end else begin
      m_count = (m_count == 0) ? int'(TopCount) : m_count - 1;
    end
  endfunction

  // Applies one request to the predictor and returns the status it produces.
  function automatic out_t advance_positioner(in_t req);
    out_t res;
    bit   edge_a;
    bit   edge_b;
    bit   boundary;
    bit   level;
    int   hp;
    int   angle;
    int   scaled;
    int   cent;
    if (req.kind == KindTick) begin
      edge_a = (req.enc_a != m_last_a);
      edge_b = (req.enc_b != m_last_b);
      if (m_since_edge < EdgeSatur) m_since_edge++;
      // When both lines move in one tick, channel A decides the direction.
      if ((edge_a || edge_b) && m_since_edge > int'(m_lockout)) begin
        if (edge_a) bump_count(req.enc_a == req.enc_b);
        else bump_count(req.enc_a != req.enc_b);
        m_since_edge = 0;
      end
      m_last_a = req.enc_a;
      m_last_b = req.enc_b;
      // A zero half period behaves like one tick.
      hp = (m_half_period == '0) ? 1 : int'(m_half_period);
      boundary = (m_half_timer == 0) && !m_phase;
      if (boundary && m_move_active && m_count == m_move_target) m_move_active = 1'b0;
      // A started pulse always runs to its end, even if stepping is turned off.
      if (!m_move_active && !m_run_en && boundary) begin
        m_half_timer = 0;
        m_phase      = 1'b0;
        level        = 1'b0;
      end else begin
        level = !m_phase;
        m_half_timer++;
        if (m_half_timer >= hp) begin
          m_half_timer = 0;
          m_phase      = !m_phase;
        end
      end
    end else begin
      angle = int'(req.target_angle);
      if (angle > int'(AngleMax)) angle = int'(AngleMax);
      scaled        = angle * int'(TopCount);
      m_move_target = scaled / DegPerTurn;
      m_move_dir    = (scaled < m_count * DegPerTurn) ? 1'b0 : 1'b1;
      m_move_active = 1'b1;
      // A move request does not advance time; it only reports the level.
      level = (m_half_timer != 0 || m_phase) && !m_phase;
    end
    cent = (m_count * int'(CentTop) + int'(TopCount) / 2) / int'(TopCount);
    res.step_out          = level;
    res.dir_out           = m_move_active ? m_move_dir : m_run_dir;
    res.drive_enable      = m_move_active | m_run_en;
    res.position_count    = m_count[CountW-1:0];
    res.position_centideg = cent[CentW-1:0];
    res.moving            = m_move_active;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_status(input out_t got);
    out_t want;
    if (pending_status.size() == 0) begin
      flag_mismatch("status result arrived with no request outstanding");
      return;
    end
    want = pending_status.pop_front();
    if (got.step_out !== want.step_out)
      flag_mismatch($sformatf("step_out %0b, predicted %0b", got.step_out, want.step_out));
    if (got.dir_out !== want.dir_out)
      flag_mismatch($sformatf("dir_out %0b, predicted %0b", got.dir_out, want.dir_out));
    if (got.drive_enable !== want.drive_enable)
      flag_mismatch($sformatf("drive_enable %0b, predicted %0b",
                              got.drive_enable, want.drive_enable));
    if (got.position_count !== want.position_count)
      flag_mismatch($sformatf("position_count %0d, predicted %0d",
                              got.position_count, want.position_count));
    if (got.position_centideg !== want.position_centideg)
      flag_mismatch($sformatf("position_centideg %0d, predicted %0d",
                              got.position_centideg, want.position_centideg));
    if (got.moving !== want.moving)
      flag_mismatch($sformatf("moving %0b, predicted %0b", got.moving, want.moving));
  endtask

  // Offers one request after a random gap and waits until the block takes it.
  // Valid is only lowered when a gap follows, so a back-to-back request never
  // sees valid dropped and raised within one time step.
  task automatic send_request(input in_t req);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_status.push_back(advance_positioner(req));
    items_sent++;
  endtask

  // Tick request; the angle field is ignored by the block but still random.
  task automatic send_tick(input logic a, input logic b);
    in_t req;
    req.kind         = KindTick;
    req.enc_a        = a;
    req.enc_b        = b;
    req.target_angle = AngleW'($urandom_range(0, 511));
    send_request(req);
  endtask

  task automatic send_move(input int angle);
    in_t req;
    req.kind         = KindMove;
    req.enc_a        = 1'($urandom_range(0, 1));
    req.enc_b        = 1'($urandom_range(0, 1));
    req.target_angle = AngleW'(angle);
    send_request(req);
  endtask

  // One quadrature step from the current line levels. Counting up the
  // lines go 00, 01, 11, 10 and back to 00; counting down is the reverse.
  task automatic step_encoder(input bit up);
    logic [1:0] ab;
    case ({m_last_a, m_last_b})
      2'b00:   ab = up ? 2'b01 : 2'b10;
      2'b01:   ab = up ? 2'b11 : 2'b00;
      2'b11:   ab = up ? 2'b10 : 2'b01;
      default: ab = up ? 2'b00 : 2'b11;
    endcase
    send_tick(ab[1], ab[0]);
  endtask

  // Holds the lines for a few ticks so that most edges clear the lockout.
  task automatic hold_lines();
    int span;
    span = (m_lockout < 8) ? int'(m_lockout) + 2 : 3;
    repeat ($urandom_range(0, span)) send_tick(m_last_a, m_last_b);
  endtask

  // Lets every outstanding status drain before the block is reconfigured.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Keeps cfg_valid_i high across back-to-back writes; configure drops it.
  task automatic write_register(input cfg_idx_e idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgHalfPeriod: m_half_period = value[HalfW-1:0];
      CfgRunEnable:  m_run_en      = value[0];
      CfgRunDir:     m_run_dir     = value[0];
      CfgLockout:    m_lockout     = value[LockW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int half_period, input int run_en, input int run_dir,
                           input int lockout);
    settle_block();
    write_register(CfgHalfPeriod, half_period);
    write_register(CfgRunEnable, run_en);
    write_register(CfgRunDir, run_dir);
    write_register(CfgLockout, lockout);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Encoder edge cases under the reset configuration, then wrap-around in
  // both directions with the lockout removed and a zero half period.
  task automatic test_encoder_edges();
    sender_gap_max   = 4;
    receiver_gap_max = 4;
    send_tick(1'b0, 1'b0);
    // Both lines change: only the A edge counts, and A equals B, so up.
    send_tick(1'b1, 1'b1);
    // Immediately back: still inside the lockout window, so ignored.
    send_tick(1'b0, 1'b0);
    configure(0, 0, 1, 0);
    repeat (3) step_encoder(1'b0);
    repeat (3) step_encoder(1'b1);
  endtask

  // Move handling: saturation, replacement, completion, unreachable targets,
  // a full lockout and a pulse that still finishes after the free run is disabled.
  task automatic test_move_cases();
    configure(3, 1, 0, int'(EdgeSatur));
    send_tick(m_last_a, m_last_b);
    // Free run turned off with the first pulse half done; it must finish.
    configure(3, 0, 0, int'(EdgeSatur));
    repeat (4) send_tick(m_last_a, m_last_b);
    send_move(511);
    send_move(0);
    // With the maximum lockout no edge is ever accepted.
    step_encoder(1'b0);
    configure(1, 0, 1, 0);
    step_encoder(1'b0);
    repeat (2) send_tick(m_last_a, m_last_b);
    // Full-turn target that is never reached: the move stays active.
    send_move(int'(AngleMax));
    repeat (2) send_tick(m_last_a, m_last_b);
  endtask

  // Random traffic. Most of it is well-formed: a move to a nearby angle
  // followed by a quadrature walk toward the target, so moves really end.
  // Walks stop once the quota is used up, which keeps the request count close
  // to the quota.
  task automatic run_random_phase(input int quota);
    int stop_at;
    int pick;
    int angle;
    int walked;
    bit up;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        if ($urandom_range(0, 3) == 0) begin
          angle = $urandom_range(0, 511);
        end else begin
          angle = m_count * DegPerTurn / int'(TopCount) + $urandom_range(0, 12) - 6;
          if (angle < 0) angle = 0;
        end
        send_move(angle);
        walked = 0;
        while (m_move_active && walked < 40 && items_sent < stop_at) begin
          hold_lines();
          // On target the move waits for a pulse boundary to finish.
          if (m_count == m_move_target) send_tick(m_last_a, m_last_b);
          else step_encoder(m_move_target > m_count);
          walked++;
        end
      end else if (pick < 8) begin
        up = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 10)) begin
          if (items_sent < stop_at) begin
            hold_lines();
            step_encoder(up);
          end
        end
      end else if (pick == 8) begin
        // Noise: arbitrary line levels, including both lines changing.
        repeat ($urandom_range(1, 6))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        send_move($urandom_range(0, 511));
      end
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // result path fills and the block must stall its request input.
  task automatic test_backpressure_fill();
    configure(2, 1, 0, 3);
    sender_gap_max   = 0;
    receiver_gap_max = 0;
    hold_off_left    = 80;
    run_random_phase(30);
    sender_gap_max   = 18;
    receiver_gap_max = 18;
    run_random_phase(100);
  endtask

  task automatic test_random_walks();
    // No idling on either side.
    configure(1, 0, 1, 0);
    sender_gap_max   = 0;
    receiver_gap_max = 0;
    run_random_phase(100);
    test_backpressure_fill();
    // Extremes: longest half period and a lockout that blocks every edge.
    configure(65535, 1, 1, int'(EdgeSatur));
    sender_gap_max   = 3;
    receiver_gap_max = 18;
    run_random_phase(40);
    configure($urandom_range(1, 5), $urandom_range(0, 1), $urandom_range(0, 1),
              $urandom_range(0, 8));
    sender_gap_max   = 18;
    receiver_gap_max = 3;
    run_random_phase(130);
  endtask

  // Result side: checks every accepted status, then draws a stall for the
  // next one. A pending hold-off takes priority over the per-result stall.
  initial begin : result_monitor
    int stall_left;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        check_status(out_data_o);
        stall_left = $urandom_range(0, receiver_gap_max);
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    mismatch_count   = 0;
    items_sent       = 0;
    hold_off_left    = 0;
    sender_gap_max   = 0;
    receiver_gap_max = 0;
    reset_model();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgHalfPeriod;
    cfg_data_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encoder_edges();
    test_move_cases();
    test_random_walks();
    settle_block();
    repeat (5) @(posedge clk_i);
    if (pending_status.size() != 0)
      flag_mismatch($sformatf("%0d status results never arrived", pending_status.size()));
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
src/sepc_pkg.sv
src/sepc_encoder.sv
src/sepc_positioner.sv
src/sepc_out_buf.sv
src/stepper_encoder_position_controller.sv
src/sepc_checker.sv
test/tb.sv
